// ===== hdl/mcg_pkg.sv =====
// mcg_pkg: shared constants, types and helper functions of the mipmap chain generator
// used by every module in hdl; depends on nothing
package mcg_pkg;

	localparam int MAX_DIM     = 64;
	localparam int MAX_LEVELS  = 7;
	localparam int CHAIN_DEPTH = (MAX_DIM * MAX_DIM * 4) / 3 + 1;
	localparam int ADDR_W      = $clog2(CHAIN_DEPTH);
	localparam int DIM_W       = 7;
	localparam int LVL_W       = 3;
	localparam int PIX_W       = 32;
	localparam int OFFB_W      = 15;
	localparam int CH_W        = 8;
	localparam int NUM_CH      = PIX_W / CH_W;
	localparam int SUM_W       = CH_W + 2;
	localparam int CFG_IDX_W   = 1;

	localparam logic [1:0] KIND_LOAD     = 2'd0;
	localparam logic [1:0] KIND_READ_PIX = 2'd1;
	localparam logic [1:0] KIND_READ_OFF = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DONE = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_GEN,
		TOP_REPLY
	} top_state_t;

	typedef enum logic [1:0] {
		GEN_IDLE,
		GEN_LEVEL,
		GEN_READ,
		GEN_WRITE
	} gen_state_t;

	typedef struct packed {
		logic              re;
		logic [ADDR_W-1:0] raddr;
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [PIX_W-1:0]  wdata;
	} mem_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} gen_stat_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		r = v;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > DIM_W'(MAX_DIM))
			r = DIM_W'(MAX_DIM);
		return r;
	endfunction

	function automatic logic [LVL_W-1:0] ceil_log2(input logic [DIM_W-1:0] v);
		logic [LVL_W-1:0] k;
		k = '0;
		for (int i = 0; i < DIM_W - 1; i++) begin
			if ((DIM_W'(1) << i) < v)
				k = k + LVL_W'(1);
		end
		return k;
	endfunction

	function automatic logic [LVL_W-1:0] level_total(input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h);
		logic [LVL_W-1:0] lw;
		logic [LVL_W-1:0] lh;
		logic [LVL_W:0]   n;
		lw = ceil_log2(w);
		lh = ceil_log2(h);
		n = {1'b0, (lw > lh) ? lw : lh} + (LVL_W+1)'(1);
		if (n > (LVL_W+1)'(MAX_LEVELS))
			n = (LVL_W+1)'(MAX_LEVELS);
		return n[LVL_W-1:0];
	endfunction

endpackage

// ===== hdl/mcg_chain_ram.sv =====
// mcg_chain_ram: single-port-write, single-port-read chain store with registered read data
// depends on mcg_pkg
module mcg_chain_ram (
	input  logic                         clk,
	input  logic                         re,
	input  logic [mcg_pkg::ADDR_W-1:0]   raddr,
	input  logic                         we,
	input  logic [mcg_pkg::ADDR_W-1:0]   waddr,
	input  logic [mcg_pkg::PIX_W-1:0]    wdata,
	output logic [mcg_pkg::PIX_W-1:0]    rdata
);

	logic [mcg_pkg::PIX_W-1:0] mem_q [mcg_pkg::CHAIN_DEPTH];
	logic [mcg_pkg::PIX_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/mcg_box_acc.sv =====
// mcg_box_acc: shared per-channel accumulator of the 2x2 box filter with rounding
// depends on mcg_pkg
module mcg_box_acc (
	input  logic                         clk,
	input  logic                         clr,
	input  logic                         add,
	input  logic [mcg_pkg::PIX_W-1:0]    data,
	output logic [mcg_pkg::PIX_W-1:0]    result
);

	logic [mcg_pkg::SUM_W-1:0] acc_q [mcg_pkg::NUM_CH];
	logic [mcg_pkg::SUM_W-1:0] sum [mcg_pkg::NUM_CH];

	always_comb begin
		for (int c = 0; c < mcg_pkg::NUM_CH; c++) begin
			sum[c] = acc_q[c] + mcg_pkg::SUM_W'(data[c*mcg_pkg::CH_W +: mcg_pkg::CH_W]);
			result[c*mcg_pkg::CH_W +: mcg_pkg::CH_W] = sum[c][mcg_pkg::SUM_W-1:2];
		end
	end

	// rounding bias loaded on clear
	always_ff @(posedge clk) begin
		for (int c = 0; c < mcg_pkg::NUM_CH; c++) begin
			if (clr)
				acc_q[c] <= mcg_pkg::SUM_W'(2);
			else if (add)
				acc_q[c] <= sum[c];
		end
	end

endmodule

// ===== hdl/mcg_gen_seq.sv =====
// mcg_gen_seq: sequencer that walks levels, rows, columns and the four samples of each block
// depends on mcg_pkg and mcg_box_acc; records level start offsets and chain size
module mcg_gen_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [mcg_pkg::DIM_W-1:0]    width,
	input  logic [mcg_pkg::DIM_W-1:0]    height,
	input  logic [mcg_pkg::LVL_W-1:0]    levels,
	input  logic [mcg_pkg::ADDR_W-1:0]   base,
	input  logic [mcg_pkg::PIX_W-1:0]    rdata,
	input  logic [mcg_pkg::LVL_W-1:0]    lookup_level,
	output mcg_pkg::mem_req_t            mem_req,
	output mcg_pkg::gen_stat_t           stat,
	output logic [mcg_pkg::ADDR_W-1:0]   lookup_off,
	output logic [mcg_pkg::ADDR_W-1:0]   chain_size
);

	mcg_pkg::gen_state_t state_q, state_d;

	logic [mcg_pkg::LVL_W-1:0]  lv_q;
	logic [mcg_pkg::LVL_W-1:0]  nlev_q;
	logic [1:0]                 smp_q;
	logic [mcg_pkg::DIM_W-1:0]  x_q, y_q;
	logic [mcg_pkg::DIM_W-1:0]  pw_q, ph_q, src_w_q;
	logic [mcg_pkg::ADDR_W-1:0] src_off_q, lvl_start_q, row0_q, dst_q, size_q;
	logic [mcg_pkg::ADDR_W-1:0] off_q [2**mcg_pkg::LVL_W];

	logic [mcg_pkg::DIM_W-1:0]  w_sh, h_sh, pw_new, ph_new;
	logic                       last_x, last_y, lv_more;
	logic [mcg_pkg::ADDR_W-1:0] raddr;
	logic                       acc_clr, acc_add;
	logic [mcg_pkg::PIX_W-1:0]  acc_res;

	mcg_box_acc u_acc (
		.clk    (clk),
		.clr    (acc_clr),
		.add    (acc_add),
		.data   (rdata),
		.result (acc_res)
	);

	always_comb begin
		w_sh    = width >> lv_q;
		h_sh    = height >> lv_q;
		pw_new  = (w_sh == '0) ? mcg_pkg::DIM_W'(1) : w_sh;
		ph_new  = (h_sh == '0) ? mcg_pkg::DIM_W'(1) : h_sh;
		last_x  = (x_q == pw_q - mcg_pkg::DIM_W'(1));
		last_y  = (y_q == ph_q - mcg_pkg::DIM_W'(1));
		lv_more = (lv_q < nlev_q);
		// sample order: top-left, top-right, bottom-left, bottom-right
		raddr = row0_q
			+ ((smp_q[1] && ph_q > mcg_pkg::DIM_W'(1)) ? mcg_pkg::ADDR_W'(src_w_q) : '0)
			+ mcg_pkg::ADDR_W'({x_q, 1'b0})
			+ mcg_pkg::ADDR_W'(smp_q[0] && pw_q > mcg_pkg::DIM_W'(1));
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcg_pkg::GEN_IDLE:  if (start) state_d = mcg_pkg::GEN_LEVEL;
			mcg_pkg::GEN_LEVEL: state_d = lv_more ? mcg_pkg::GEN_READ : mcg_pkg::GEN_IDLE;
			mcg_pkg::GEN_READ:  if (smp_q == 2'd3) state_d = mcg_pkg::GEN_WRITE;
			mcg_pkg::GEN_WRITE: begin
				state_d = (last_x && last_y) ? mcg_pkg::GEN_LEVEL : mcg_pkg::GEN_READ;
			end
			default:            state_d = mcg_pkg::GEN_IDLE;
		endcase
	end

	always_comb begin
		mem_req       = '0;
		stat          = '0;
		acc_clr       = 1'b0;
		acc_add       = 1'b0;
		mem_req.raddr = raddr;
		mem_req.waddr = dst_q;
		mem_req.wdata = acc_res;
		case (state_q)
			mcg_pkg::GEN_IDLE: ;
			mcg_pkg::GEN_LEVEL: begin
				stat.busy = 1'b1;
				stat.done = !lv_more;
			end
			mcg_pkg::GEN_READ: begin
				stat.busy  = 1'b1;
				mem_req.re = 1'b1;
				acc_clr    = (smp_q == 2'd0);
				acc_add    = (smp_q != 2'd0);
			end
			mcg_pkg::GEN_WRITE: begin
				stat.busy  = 1'b1;
				mem_req.we = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcg_pkg::GEN_IDLE;
			lv_q    <= '0;
			nlev_q  <= '0;
			smp_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				mcg_pkg::GEN_IDLE: begin
					if (start) begin
						lv_q   <= mcg_pkg::LVL_W'(1);
						nlev_q <= levels;
					end
				end
				mcg_pkg::GEN_LEVEL: smp_q <= '0;
				mcg_pkg::GEN_READ:  smp_q <= smp_q + 2'd1;
				mcg_pkg::GEN_WRITE: if (last_x && last_y) lv_q <= lv_q + mcg_pkg::LVL_W'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			mcg_pkg::GEN_IDLE: begin
				if (start) begin
					src_off_q <= '0;
					src_w_q   <= width;
					dst_q     <= base;
					off_q[0]  <= '0;
				end
			end
			mcg_pkg::GEN_LEVEL: begin
				if (lv_more) begin
					pw_q        <= pw_new;
					ph_q        <= ph_new;
					off_q[lv_q] <= dst_q;
					lvl_start_q <= dst_q;
					row0_q      <= src_off_q;
					x_q         <= '0;
					y_q         <= '0;
				end else begin
					size_q <= dst_q;
				end
			end
			mcg_pkg::GEN_WRITE: begin
				dst_q <= dst_q + mcg_pkg::ADDR_W'(1);
				if (last_x) begin
					x_q    <= '0;
					row0_q <= row0_q + mcg_pkg::ADDR_W'({src_w_q, 1'b0});
					if (last_y) begin
						src_off_q <= lvl_start_q;
						src_w_q   <= pw_q;
					end else begin
						y_q <= y_q + mcg_pkg::DIM_W'(1);
					end
				end else begin
					x_q <= x_q + mcg_pkg::DIM_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign lookup_off = off_q[lookup_level];
	assign chain_size = size_q;

endmodule

// ===== hdl/mipmap_chain_generator.sv =====
// mipmap_chain_generator: top level; loads level zero, runs chain generation, answers reads
// depends on mcg_pkg, mcg_chain_ram, mcg_gen_seq
// a load is written to the ram on acceptance; a read's beat is registered from the reply state
// throughput: one load per cycle until the last; a new read waits until the last reply is out
// the last pixel starts generation: four ram reads and one write per built pixel, level by level
// reset: asynchronous, clears control state, sets the image to 64 x 64; the ram is not cleared
module mipmap_chain_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [47:0]                     s_tdata,   // pixel_in, chain_address, level_select
	input  logic [1:0]                      s_tuser,   // kind
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [55:0]                     m_tdata,   // pixel_out, level_offset_bytes, level_count
	output logic [1:0]                      m_tuser,   // status
	input  logic                            cfg_we,
	input  logic [mcg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mcg_pkg::DIM_W-1:0]       cfg_data
);

	mcg_pkg::top_state_t state_q, state_d;

	logic [mcg_pkg::DIM_W-1:0]   width_q, height_q;
	logic [mcg_pkg::ADDR_W-1:0]  load_cnt_q;
	logic [mcg_pkg::LVL_W-1:0]   levels_q;
	logic                        ready_q;
	logic [1:0]                  rep_status_q;
	logic [mcg_pkg::OFFB_W-1:0]  rep_offb_q;
	logic                        rep_pix_q;
	logic                        m_tvalid_q;
	logic [mcg_pkg::PIX_W-1:0]   out_pix_q;
	logic [mcg_pkg::OFFB_W-1:0]  out_offb_q;
	logic [mcg_pkg::LVL_W-1:0]   out_lvls_q;
	logic [1:0]                  out_status_q;

	logic [mcg_pkg::PIX_W-1:0]   pixel_in;
	logic [mcg_pkg::ADDR_W-1:0]  chain_address;
	logic [mcg_pkg::LVL_W-1:0]   level_select;
	logic [1:0]                  kind;
	logic [mcg_pkg::DIM_W-1:0]   w, h;
	logic [2*mcg_pkg::DIM_W-1:0] area;
	logic [mcg_pkg::LVL_W-1:0]   new_levels;
	logic [mcg_pkg::ADDR_W-1:0]  load_idx, cnt_next;
	logic                        accept, is_load, last_load, out_free, out_load;
	logic                        pix_ok, off_ok, gen_start;
	logic [mcg_pkg::ADDR_W-1:0]  lookup_off, chain_size;
	logic [mcg_pkg::PIX_W-1:0]   rdata;
	mcg_pkg::mem_req_t           top_req, gen_req, mem_req;
	mcg_pkg::gen_stat_t          gen_stat;

	assign pixel_in      = s_tdata[31:0];
	assign chain_address = s_tdata[44:32];
	assign level_select  = s_tdata[47:45];
	assign kind          = s_tuser;

	always_comb begin
		w          = mcg_pkg::clamp_dim(width_q);
		h          = mcg_pkg::clamp_dim(height_q);
		area       = (2*mcg_pkg::DIM_W)'(w) * (2*mcg_pkg::DIM_W)'(h);
		new_levels = mcg_pkg::level_total(w, h);
		load_idx   = ready_q ? '0 : load_cnt_q;
		cnt_next   = load_idx + mcg_pkg::ADDR_W'(1);
		accept     = s_tvalid && (state_q == mcg_pkg::TOP_IDLE);
		is_load    = (kind == mcg_pkg::KIND_LOAD);
		last_load  = ({1'b0, cnt_next} >= area);
		out_free   = !m_tvalid_q || m_tready;
		pix_ok     = ready_q && (chain_address < chain_size);
		off_ok     = ready_q && (level_select < levels_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcg_pkg::TOP_IDLE: begin
				if (accept)
					state_d = !is_load ? mcg_pkg::TOP_REPLY
						: (last_load ? mcg_pkg::TOP_GEN : mcg_pkg::TOP_IDLE);
			end
			mcg_pkg::TOP_GEN:   if (gen_stat.done) state_d = mcg_pkg::TOP_REPLY;
			mcg_pkg::TOP_REPLY: if (out_free) state_d = mcg_pkg::TOP_IDLE;
			default:            state_d = mcg_pkg::TOP_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		gen_start     = 1'b0;
		out_load      = 1'b0;
		top_req       = '0;
		top_req.raddr = chain_address;
		top_req.waddr = load_idx;
		top_req.wdata = pixel_in;
		mem_req       = top_req;
		case (state_q)
			mcg_pkg::TOP_IDLE: begin
				s_tready   = 1'b1;
				top_req.we = accept && is_load;
				top_req.re = accept && (kind == mcg_pkg::KIND_READ_PIX);
				gen_start  = accept && is_load && last_load;
				mem_req    = top_req;
			end
			mcg_pkg::TOP_GEN:   mem_req  = gen_req;
			mcg_pkg::TOP_REPLY: out_load = out_free;
			default: ;
		endcase
	end

	mcg_chain_ram u_ram (
		.clk   (clk),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	mcg_gen_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (gen_start),
		.width        (w),
		.height       (h),
		.levels       (new_levels),
		.base         (cnt_next),
		.rdata        (rdata),
		.lookup_level (level_select),
		.mem_req      (gen_req),
		.stat         (gen_stat),
		.lookup_off   (lookup_off),
		.chain_size   (chain_size)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mcg_pkg::TOP_IDLE;
			width_q    <= mcg_pkg::DIM_W'(mcg_pkg::MAX_DIM);
			height_q   <= mcg_pkg::DIM_W'(mcg_pkg::MAX_DIM);
			load_cnt_q <= '0;
			levels_q   <= mcg_pkg::LVL_W'(1);
			ready_q    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == mcg_pkg::CFG_WIDTH)
					width_q <= cfg_data;
				if (cfg_index == mcg_pkg::CFG_HEIGHT)
					height_q <= cfg_data;
				load_cnt_q <= '0;
				ready_q    <= 1'b0;
			end
			if (accept && is_load) begin
				load_cnt_q <= cnt_next;
				ready_q    <= 1'b0;
				if (last_load)
					levels_q <= new_levels;
			end
			if (state_q == mcg_pkg::TOP_GEN && gen_stat.done)
				ready_q <= 1'b1;
			if (out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rep_pix_q    <= 1'b0;
			rep_offb_q   <= '0;
			rep_status_q <= mcg_pkg::ST_ERR;
			case (kind)
				mcg_pkg::KIND_LOAD: rep_status_q <= mcg_pkg::ST_DONE;
				mcg_pkg::KIND_READ_PIX: begin
					rep_pix_q <= pix_ok;
					if (pix_ok)
						rep_status_q <= mcg_pkg::ST_OK;
				end
				mcg_pkg::KIND_READ_OFF: begin
					if (off_ok) begin
						rep_offb_q   <= {lookup_off, 2'b00};
						rep_status_q <= mcg_pkg::ST_OK;
					end
				end
				default: ;
			endcase
		end
		if (out_load) begin
			out_pix_q    <= rep_pix_q ? rdata : '0;
			out_offb_q   <= rep_offb_q;
			out_lvls_q   <= levels_q;
			out_status_q <= rep_status_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'b0, out_lvls_q, out_offb_q, out_pix_q};
	assign m_tuser  = out_status_q;

	a_no_accept_while_gen: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && gen_stat.busy))
		else $error("input taken while generation runs");

	a_done_in_gen: assert property (@(posedge clk) disable iff (!arst_n)
		gen_stat.done |-> state_q == mcg_pkg::TOP_GEN)
		else $error("generation finished outside the generation phase");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> mem_req.waddr < mcg_pkg::ADDR_W'(mcg_pkg::CHAIN_DEPTH))
		else $error("chain write beyond the store");

	a_start_enters_gen: assert property (@(posedge clk) disable iff (!arst_n)
		gen_start |=> state_q == mcg_pkg::TOP_GEN && gen_stat.busy)
		else $error("generation did not start after the last pixel");

endmodule
